// File: design/rv32is_pkg.sv
package rv32is_pkg;

  // Data memory geometry: four byte lanes, one per low address code
  localparam int DMEM_BYTES = 4096;
  localparam int DMEM_AW    = $clog2(DMEM_BYTES);
  localparam int DMEM_ROWS  = DMEM_BYTES / 4;
  localparam int DMEM_RW    = DMEM_AW - 2;

  // Request kinds
  localparam logic [1:0] REQ_EXEC    = 2'd0;
  localparam logic [1:0] REQ_PRELOAD = 2'd1;
  localparam logic [1:0] REQ_SET_PC  = 2'd2;

  // Trap codes
  localparam logic [1:0] TRAP_NONE    = 2'd0;
  localparam logic [1:0] TRAP_ECALL   = 2'd1;
  localparam logic [1:0] TRAP_EBREAK  = 2'd2;
  localparam logic [1:0] TRAP_ILLEGAL = 2'd3;

  // Major opcodes
  localparam logic [6:0] OPC_OP     = 7'h33;
  localparam logic [6:0] OPC_OP_IMM = 7'h13;
  localparam logic [6:0] OPC_LOAD   = 7'h03;
  localparam logic [6:0] OPC_STORE  = 7'h23;
  localparam logic [6:0] OPC_BRANCH = 7'h63;
  localparam logic [6:0] OPC_JAL    = 7'h6F;
  localparam logic [6:0] OPC_JALR   = 7'h67;
  localparam logic [6:0] OPC_LUI    = 7'h37;
  localparam logic [6:0] OPC_AUIPC  = 7'h17;
  localparam logic [6:0] OPC_FENCE  = 7'h0F;
  localparam logic [6:0] OPC_SYSTEM = 7'h73;

  localparam logic [31:0] WORD_ECALL  = 32'h0000_0073;
  localparam logic [31:0] WORD_EBREAK = 32'h0010_0073;

  localparam logic [6:0] F7_BASE = 7'h00;
  localparam logic [6:0] F7_ALT  = 7'h20;

endpackage

// File: design/rv32i_instruction_step_top.sv
// Channel  Direction  Handshake            Beat contents
// in       input      in_valid/in_ready    req_type instr_word preload_addr preload_byte jump_target
// out      output     out_valid/out_ready  pc_after reg_written dest_reg dest_value mem_written trap_code
//
// An accepted beat's register reads complete in the cycle after it is taken; most requests can
// then finish at once, so a new beat is taken every cycle while the output side is free. A load
// first registers its data memory read and finishes afterwards, holding new beats meanwhile. A result
// register parts the output side, and a new beat is taken while a finished result waits. Reset clears
// the program counter and the register valid bits; data memory holds nothing defined until written.
module rv32i_instruction_step_top
  import rv32is_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  req_type,
  input  logic [31:0] instr_word,
  input  logic [11:0] preload_addr,
  input  logic [7:0]  preload_byte,
  input  logic [31:0] jump_target,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] pc_after,
  output logic        reg_written,
  output logic [4:0]  dest_reg,
  output logic [31:0] dest_value,
  output logic        mem_written,
  output logic [1:0]  trap_code
);

  // Register file copies, one per read port
  logic [31:0] rf_a [32];
  logic [31:0] rf_b [32];
  logic [31:0] rf_a_q, rf_b_q;
  logic [31:0] rf_valid;
  logic        fwd_v;
  logic [4:0]  fwd_rd;
  logic [31:0] fwd_val;

  // Data memory byte lanes
  logic [7:0] dmem [4][DMEM_ROWS];
  logic [7:0] dm_rd [4];
  logic [DMEM_RW-1:0] dm_row [4];
  logic [7:0] dm_wd [4];
  logic [3:0] dm_we;

  // Execute stage
  logic        st_valid, phase;
  logic [1:0]  st_req;
  logic [31:0] st_w;
  logic [11:0] st_pl_addr;
  logic [7:0]  st_pl_byte;
  logic [31:0] st_jump;
  logic [1:0]  ld_lo;
  logic [31:0] pc;

  logic        accept, done, finish, ld_go, st_go;
  logic [31:0] a, b, immi, imms, immb, immj, ad, nxt, val, alu_res;
  logic [1:0]  trap;
  logic        wr, memw, alt, alu_ok;
  logic [4:0]  rd, rs1, rs2;
  logic [6:0]  op, f7;
  logic [2:0]  f3;
  logic [31:0] pl_ext;
  logic [DMEM_AW-1:0] mem_base;
  logic [7:0]  lb [4];
  logic [31:0] ld_word;

  function automatic logic [31:0] alu_f(input logic [2:0] fn, input logic sub_op,
                                        input logic arith, input logic [31:0] x,
                                        input logic [31:0] y);
    logic [4:0] sh;
    logic [31:0] r;
    sh = y[4:0];
    case (fn)
      3'd0:    r = sub_op ? x - y : x + y;
      3'd1:    r = x << sh;
      3'd2:    r = {31'b0, $signed(x) < $signed(y)};
      3'd3:    r = {31'b0, x < y};
      3'd4:    r = x ^ y;
      3'd5:    r = arith ? 32'($signed(x) >>> sh) : x >> sh;
      3'd6:    r = x | y;
      default: r = x & y;
    endcase
    return r;
  endfunction

  assign accept   = in_valid && in_ready;
  assign finish   = !ld_go;
  assign done     = st_valid && finish && (!out_valid || out_ready);
  assign in_ready = !st_valid || done;

  // Operand fields and forwarded register reads
  assign op  = st_w[6:0];
  assign f3  = st_w[14:12];
  assign f7  = st_w[31:25];
  assign rs1 = st_w[19:15];
  assign rs2 = st_w[24:20];
  assign a = (fwd_v && fwd_rd == rs1) ? fwd_val : (rf_valid[rs1] ? rf_a_q : 32'b0);
  assign b = (fwd_v && fwd_rd == rs2) ? fwd_val : (rf_valid[rs2] ? rf_b_q : 32'b0);
  assign immi = {{20{st_w[31]}}, st_w[31:20]};
  assign imms = {{20{st_w[31]}}, st_w[31:25], st_w[11:7]};
  assign immb = {{19{st_w[31]}}, st_w[31], st_w[7], st_w[30:25], st_w[11:8], 1'b0};
  assign immj = {{11{st_w[31]}}, st_w[31], st_w[19:12], st_w[20], st_w[30:21], 1'b0};
  assign ad   = a + ((op == OPC_STORE) ? imms : immi);

  // Assemble load bytes from the lanes
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      lb[i] = dm_rd[2'(ld_lo + 2'(i))];
    end
    ld_word = {lb[3], lb[2], lb[1], lb[0]};
  end

  // Decode and execute
  always_comb begin
    trap    = TRAP_NONE;
    wr      = 1'b0;
    val     = 32'b0;
    nxt     = pc + 32'd4;
    memw    = 1'b0;
    ld_go   = 1'b0;
    st_go   = 1'b0;
    rd      = st_w[11:7];
    alt     = 1'b0;
    alu_ok  = 1'b1;
    alu_res = 32'b0;
    case (st_req)
      REQ_PRELOAD: begin
        memw = 1'b1;
        nxt  = pc;
      end
      REQ_SET_PC: nxt = st_jump;
      REQ_EXEC: begin
        case (op)
          OPC_OP: begin
            alt     = (f7 == F7_ALT);
            alu_res = alu_f(f3, alt, alt, a, b);
            if (f7 != F7_BASE && f7 != F7_ALT) trap = TRAP_ILLEGAL;
            else if (alt && f3 != 3'd0 && f3 != 3'd5) trap = TRAP_ILLEGAL;
            else begin
              wr  = 1'b1;
              val = alu_res;
            end
          end
          OPC_OP_IMM: begin
            if (f3 == 3'd1 || f3 == 3'd5) begin
              alt = (f7 == F7_ALT);
              if (f7 != F7_BASE && f7 != F7_ALT) alu_ok = 1'b0;
              if (f3 == 3'd1 && alt) alu_ok = 1'b0;
            end
            alu_res = alu_f(f3, 1'b0, alt, a, immi);
            if (!alu_ok) trap = TRAP_ILLEGAL;
            else begin
              wr  = 1'b1;
              val = alu_res;
            end
          end
          OPC_LOAD: begin
            case (f3)
              3'd0, 3'd1, 3'd2, 3'd4, 3'd5: begin
                if (!phase) ld_go = 1'b1;
                else begin
                  wr = 1'b1;
                  case (f3)
                    3'd0:    val = {{24{ld_word[7]}}, ld_word[7:0]};
                    3'd1:    val = {{16{ld_word[15]}}, ld_word[15:0]};
                    3'd4:    val = {24'b0, ld_word[7:0]};
                    3'd5:    val = {16'b0, ld_word[15:0]};
                    default: val = ld_word;
                  endcase
                end
              end
              default: trap = TRAP_ILLEGAL;
            endcase
          end
          OPC_STORE: begin
            if (f3 > 3'd2) trap = TRAP_ILLEGAL;
            else begin
              memw  = 1'b1;
              st_go = 1'b1;
            end
          end
          OPC_BRANCH: begin
            case (f3)
              3'd0: if (a == b) nxt = pc + immb;
              3'd1: if (a != b) nxt = pc + immb;
              3'd4: if ($signed(a) < $signed(b)) nxt = pc + immb;
              3'd5: if ($signed(a) >= $signed(b)) nxt = pc + immb;
              3'd6: if (a < b) nxt = pc + immb;
              3'd7: if (a >= b) nxt = pc + immb;
              default: trap = TRAP_ILLEGAL;
            endcase
          end
          OPC_JAL: begin
            wr  = 1'b1;
            val = pc + 32'd4;
            nxt = pc + immj;
          end
          OPC_JALR: begin
            if (f3 != 3'd0) trap = TRAP_ILLEGAL;
            else begin
              wr  = 1'b1;
              val = pc + 32'd4;
              nxt = a + immi;
            end
          end
          OPC_LUI: begin
            wr  = 1'b1;
            val = {st_w[31:12], 12'b0};
          end
          OPC_AUIPC: begin
            wr  = 1'b1;
            val = pc + {st_w[31:12], 12'b0};
          end
          OPC_FENCE: if (f3 != 3'd0) trap = TRAP_ILLEGAL;
          OPC_SYSTEM: begin
            if (st_w == WORD_ECALL) trap = TRAP_ECALL;
            else if (st_w == WORD_EBREAK) trap = TRAP_EBREAK;
            else trap = TRAP_ILLEGAL;
          end
          default: trap = TRAP_ILLEGAL;
        endcase
        if (trap != TRAP_NONE) begin
          nxt   = pc;
          wr    = 1'b0;
          val   = 32'b0;
          memw  = 1'b0;
          st_go = 1'b0;
        end
      end
      default: nxt = pc;
    endcase
    if (!(wr && rd != 5'd0)) begin
      wr  = 1'b0;
      val = 32'b0;
      rd  = 5'd0;
    end
  end

  // Lane addresses, store data and write enables
  assign pl_ext   = {20'b0, st_pl_addr};
  assign mem_base = (st_req == REQ_PRELOAD) ? pl_ext[DMEM_AW-1:0] : ad[DMEM_AW-1:0];

  always_comb begin
    logic [1:0]         off;
    logic [DMEM_AW-1:0] ab;
    for (int k = 0; k < 4; k++) begin
      off       = 2'(k) - mem_base[1:0];
      ab        = mem_base + DMEM_AW'(off);
      dm_row[k] = ab[DMEM_AW-1:2];
      if (st_req == REQ_PRELOAD) begin
        dm_wd[k] = st_pl_byte;
        dm_we[k] = done && (off == 2'd0);
      end else begin
        dm_wd[k] = 8'(b >> {off, 3'b000});
        dm_we[k] = done && st_go && ({1'b0, off} < (3'd1 << f3[1:0]));
      end
    end
  end

  // Data memory lanes
  always_ff @(posedge clk) begin
    for (int k = 0; k < 4; k++) begin
      if (dm_we[k]) dmem[k][dm_row[k]] <= dm_wd[k];
      if (ld_go) dm_rd[k] <= dmem[k][dm_row[k]];
    end
  end

  // Register file: write on completion, read on accept
  always_ff @(posedge clk) begin
    if (done && wr) begin
      rf_a[rd] <= val;
      rf_b[rd] <= val;
    end
    if (accept) begin
      rf_a_q <= rf_a[instr_word[19:15]];
      rf_b_q <= rf_b[instr_word[24:20]];
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid <= 1'b0;
      phase    <= 1'b0;
      pc       <= 32'b0;
      rf_valid <= 32'b0;
      fwd_v    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        st_valid <= 1'b1;
        phase    <= 1'b0;
      end else if (done) begin
        st_valid <= 1'b0;
      end else if (st_valid && ld_go) begin
        phase <= 1'b1;
      end
      if (done) begin
        pc <= nxt;
        if (wr) begin
          rf_valid[rd] <= 1'b1;
          fwd_v        <= 1'b1;
        end
      end
      if (done) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // Payload registers: stage capture, forward value and result beat
  always_ff @(posedge clk) begin
    if (accept) begin
      st_req     <= req_type;
      st_w       <= instr_word;
      st_pl_addr <= preload_addr;
      st_pl_byte <= preload_byte;
      st_jump    <= jump_target;
    end
    if (ld_go) ld_lo <= ad[1:0];
    if (done && wr) begin
      fwd_rd  <= rd;
      fwd_val <= val;
    end
    if (done) begin
      pc_after    <= nxt;
      reg_written <= wr;
      dest_reg    <= rd;
      dest_value  <= val;
      mem_written <= memw;
      trap_code   <= trap;
    end
  end

endmodule
